// ===== sv/mtpg_pkg.sv =====
// shared constants and types for the multitouch pad grid tracker
`default_nettype none

package mtpg_pkg;

  localparam int TOUCH_SLOTS = 5;
  localparam int GRID_COLS   = 4;
  localparam int GRID_ROWS   = 4;
  localparam int SLOT_W      = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;
  localparam int SCAN_STEPS  = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
  localparam int PAD_W       = 6;
  localparam int CNT_W       = 3;
  localparam int EDGE_W      = 14;

  typedef logic [PAD_W-1:0] pad_t;

  localparam logic [1:0] MODE_TOUCH = 2'd0;
  localparam logic [1:0] MODE_ENTER = 2'd1;
  localparam logic [1:0] MODE_LEAVE = 2'd2;

  localparam logic [2:0] CFG_GRID_LEFT     = 3'd0;
  localparam logic [2:0] CFG_GRID_TOP      = 3'd1;
  localparam logic [2:0] CFG_CELL_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_CELL_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_GAP_X         = 3'd4;
  localparam logic [2:0] CFG_GAP_Y         = 3'd5;
  localparam logic [2:0] CFG_ASSIGNED_MASK = 3'd6;
  localparam logic [2:0] CFG_PAD_KINDS     = 3'd7;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ENTER,
    OP_SCAN,
    OP_REL_OLD,
    OP_PRESS,
    OP_LEAVE,
    OP_LIFT
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_REL,
    ST_PRESS,
    ST_LEAVE,
    ST_LIFT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic sel_cnt;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       slot_ok;
    logic       is_down;
    logic       hit;
    logic       scan_last;
    logic       slot_last;
    logic       want_rel;
    logic       want_press;
    logic       want_leave;
    logic       want_lift;
    logic       out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/multitouch_pad_grid_tracker_unit.sv =====
// top level of the multitouch pad grid tracker
//
// input channel (in_valid/in_ready): one item per touch event or enter/leave
// command. in_ready is high only while the controller is idle; an item is
// taken even when an earlier result still waits in the result register.
// result channel (out_valid/out_ready): pad press and release events, each
// from a registered output; last marks the final event of an item.
// configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready, one register written per handshake. the user must write only while
// the block is idle; the block itself does not enforce it.
// steps per item: load, then decode. a touch press then runs the hit scan,
// one pad column and one pad row per cycle, and on a hit a release and a press
// step. a lift runs a lift step, enter ends in decode, leave steps over the
// touch slots. each result is registered and shows in the cycle after its step.
// a step that would produce a result waits while the result register is full
// and out_ready is low, so a stalled receiver holds the block in that step.
// reset clears the slot table, pad on bits and result valid, and loads the
// configuration reset values.
`default_nettype none

module multitouch_pad_grid_tracker_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [2:0]  touch_slot,
  input  wire logic [10:0] pos_x,
  input  wire logic [10:0] pos_y,
  input  wire logic        is_down,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_press,
  output logic [3:0]       pad_number,
  output logic             pad_level,
  output logic             notify,
  output logic             last
);
  import mtpg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  mtpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtpg_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mode       (mode),
    .touch_slot (touch_slot),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .is_down    (is_down),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .is_press   (is_press),
    .pad_number (pad_number),
    .pad_level  (pad_level),
    .notify     (notify),
    .last       (last)
  );

endmodule

`default_nettype wire

// ===== sv/mtpg_datapath.sv =====
// datapath: configuration, hit scan, slot table, pad state and result register
`default_nettype none

module mtpg_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mtpg_pkg::cmd_t cmd,
  output mtpg_pkg::stat_t     stat,
  input  wire logic           cfg_valid,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [31:0]    cfg_data,
  input  wire logic [1:0]     mode,
  input  wire logic [2:0]     touch_slot,
  input  wire logic [10:0]    pos_x,
  input  wire logic [10:0]    pos_y,
  input  wire logic           is_down,
  input  wire logic           out_ready,
  output logic                out_valid,
  output logic                is_press,
  output logic [3:0]          pad_number,
  output logic                pad_level,
  output logic                notify,
  output logic                last
);
  import mtpg_pkg::*;

  localparam logic [1:0] KIND_TRIGGER   = 2'd0;
  localparam logic [1:0] KIND_MOMENTARY = 2'd1;
  localparam logic [1:0] KIND_TOGGLE    = 2'd2;

  logic [10:0] grid_left, grid_top;
  logic [9:0]  cell_width, cell_height;
  logic [7:0]  gap_x, gap_y;
  logic [15:0] assigned_mask;
  logic [31:0] pad_kinds;

  logic [1:0]  cur_mode;
  logic [2:0]  cur_slot;
  logic [10:0] cur_x, cur_y;
  logic        cur_down;

  logic [CNT_W-1:0]  cnt;
  logic [EDGE_W-1:0] col_edge, row_edge;
  logic              col_found, row_found;
  logic [2:0]        col_idx, row_idx;

  logic [TOUCH_SLOTS-1:0] owner_valid;
  pad_t                   owner [TOUCH_SLOTS];
  logic [15:0]            pad_on;

  logic [EDGE_W-1:0] col_end, row_end, x_ext, y_ext;
  logic              col_in, row_in, hit;
  pad_t              hit_pad;
  logic [SLOT_W-1:0] s_idx, c_idx, rd_idx;
  logic              rd_valid;
  pad_t              rd_owner;
  logic [TOUCH_SLOTS-1:0] match_hit, match_s, emits_rel, above;
  logic              other, still, held_same, more;
  logic              want_rel, want_press, want_lift, want_leave, out_free;
  logic              ev_emit, ev_pressed, ev_last, ev_on, ev_changed, on_old;
  pad_t              ev_pad;
  logic [1:0]        ev_kind;

  function automatic logic pad_assigned(logic [15:0] msk, pad_t p);
    return (p < pad_t'(16)) && msk[p[3:0]];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_left     <= 11'd10;
      grid_top      <= 11'd40;
      cell_width    <= 10'd70;
      cell_height   <= 10'd50;
      gap_x         <= 8'd5;
      gap_y         <= 8'd5;
      assigned_mask <= 16'd0;
      pad_kinds     <= 32'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRID_LEFT:     grid_left     <= cfg_data[10:0];
        CFG_GRID_TOP:      grid_top      <= cfg_data[10:0];
        CFG_CELL_WIDTH:    cell_width    <= cfg_data[9:0];
        CFG_CELL_HEIGHT:   cell_height   <= cfg_data[9:0];
        CFG_GAP_X:         gap_x         <= cfg_data[7:0];
        CFG_GAP_Y:         gap_y         <= cfg_data[7:0];
        CFG_ASSIGNED_MASK: assigned_mask <= cfg_data[15:0];
        CFG_PAD_KINDS:     pad_kinds     <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched input item
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      cur_mode <= mode;
      cur_slot <= touch_slot;
      cur_x    <= pos_x;
      cur_y    <= pos_y;
      cur_down <= is_down;
    end
  end

  // one column and one row edge per scan step
  assign x_ext   = EDGE_W'(cur_x);
  assign y_ext   = EDGE_W'(cur_y);
  assign col_end = col_edge + EDGE_W'(cell_width);
  assign row_end = row_edge + EDGE_W'(cell_height);
  assign col_in  = ({1'b0, cnt} < 4'(GRID_COLS)) && (x_ext >= col_edge) && (x_ext < col_end);
  assign row_in  = ({1'b0, cnt} < 4'(GRID_ROWS)) && (y_ext >= row_edge) && (y_ext < row_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      col_found <= 1'b0;
      row_found <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          cnt       <= '0;
          col_found <= 1'b0;
          row_found <= 1'b0;
        end
        OP_SCAN: begin
          cnt <= cnt + 1'b1;
          if (!col_found && col_in) col_found <= 1'b1;
          if (!row_found && row_in) row_found <= 1'b1;
        end
        OP_LEAVE: cnt <= cnt + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      col_edge <= EDGE_W'(grid_left);
      row_edge <= EDGE_W'(grid_top);
    end else if (cmd.op == OP_SCAN) begin
      col_edge <= col_edge + EDGE_W'(cell_width) + EDGE_W'(gap_x);
      row_edge <= row_edge + EDGE_W'(cell_height) + EDGE_W'(gap_y);
      if (!col_found && col_in) col_idx <= cnt;
      if (!row_found && row_in) row_idx <= cnt;
    end
  end

  assign hit     = col_found && row_found;
  assign hit_pad = pad_t'(pad_t'(row_idx) * pad_t'(GRID_COLS) + pad_t'(col_idx));

  // slot table lookups
  assign s_idx    = cur_slot[SLOT_W-1:0];
  assign c_idx    = cnt[SLOT_W-1:0];
  assign rd_idx   = cmd.sel_cnt ? c_idx : s_idx;
  assign rd_valid = owner_valid[rd_idx];
  assign rd_owner = owner[rd_idx];

  always_comb begin
    for (int j = 0; j < TOUCH_SLOTS; j++) begin
      match_hit[j] = owner_valid[j] && (owner[j] == hit_pad) && (SLOT_W'(j) != s_idx);
      match_s[j]   = owner_valid[j] && (owner[j] == rd_owner) && (SLOT_W'(j) != s_idx);
      emits_rel[j] = owner_valid[j] && pad_assigned(assigned_mask, owner[j]);
      above[j]     = SLOT_W'(j) > c_idx;
    end
  end

  assign other      = |match_hit;
  assign still      = |match_s;
  assign held_same  = rd_valid && (rd_owner == hit_pad);
  assign more       = |(emits_rel & above);
  assign want_rel   = hit && rd_valid && (rd_owner != hit_pad) &&
                      pad_assigned(assigned_mask, rd_owner);
  assign want_press = hit && !other && !held_same && pad_assigned(assigned_mask, hit_pad);
  assign want_lift  = rd_valid && !still && pad_assigned(assigned_mask, rd_owner);
  assign want_leave = emits_rel[c_idx];
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    stat.mode       = cur_mode;
    stat.slot_ok    = {1'b0, cur_slot} < 4'(TOUCH_SLOTS);
    stat.is_down    = cur_down;
    stat.hit        = hit;
    stat.scan_last  = cnt == CNT_W'(SCAN_STEPS - 1);
    stat.slot_last  = cnt == CNT_W'(TOUCH_SLOTS - 1);
    stat.want_rel   = want_rel;
    stat.want_press = want_press;
    stat.want_leave = want_leave;
    stat.want_lift  = want_lift;
    stat.out_free   = out_free;
  end

  // pad event for the current command
  always_comb begin
    ev_emit    = 1'b0;
    ev_pad     = rd_owner;
    ev_pressed = 1'b0;
    ev_last    = 1'b1;
    unique case (cmd.op)
      OP_REL_OLD: begin
        ev_emit = want_rel;
        ev_last = !want_press;
      end
      OP_PRESS: begin
        ev_emit    = want_press;
        ev_pad     = hit_pad;
        ev_pressed = 1'b1;
      end
      OP_LEAVE: begin
        ev_emit = want_leave;
        ev_last = !more;
      end
      OP_LIFT: ev_emit = want_lift;
      default: ;
    endcase
  end

  assign ev_kind = pad_kinds[{ev_pad[3:0], 1'b0} +: 2];
  assign on_old  = pad_on[ev_pad[3:0]];

  always_comb begin
    case (ev_kind)
      KIND_TRIGGER: begin
        ev_on      = ev_pressed;
        ev_changed = ev_pressed;
      end
      KIND_MOMENTARY: begin
        ev_on      = ev_pressed;
        ev_changed = 1'b1;
      end
      KIND_TOGGLE: begin
        ev_on      = ev_pressed ? !on_old : on_old;
        ev_changed = ev_pressed;
      end
      default: begin
        ev_on      = on_old;
        ev_changed = 1'b0;
      end
    endcase
  end

  // slot table and pad on bits
  always_ff @(posedge clk) begin
    if (rst) begin
      owner_valid <= '0;
      pad_on      <= '0;
    end else begin
      if (ev_emit) pad_on[ev_pad[3:0]] <= ev_on;
      unique case (cmd.op)
        OP_ENTER: owner_valid        <= '0;
        OP_PRESS: owner_valid[s_idx] <= 1'b1;
        OP_LEAVE: owner_valid[c_idx] <= 1'b0;
        OP_LIFT:  owner_valid[s_idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PRESS) owner[s_idx] <= hit_pad;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ev_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_emit) begin
      is_press   <= ev_pressed;
      pad_number <= ev_pad[3:0];
      pad_level  <= ev_on;
      notify     <= ev_changed;
      last       <= ev_last;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst) ev_emit |-> out_free)
    else $error("result written over a waiting result");
  a_leave_sel: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LEAVE) |-> cmd.sel_cnt)
    else $error("leave step reads the wrong slot");
  a_press_hit: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PRESS) |-> hit)
    else $error("slot taken without a hit");
  a_reset_clean: assert property (@(posedge clk) rst |=> !out_valid && owner_valid == '0)
    else $error("state not cleared by reset");
`endif

endmodule

`default_nettype wire

// ===== sv/mtpg_ctrl.sv =====
// controller state machine sequencing load, decode, scan, release, press, leave and lift steps
`default_nettype none

module mtpg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mtpg_pkg::stat_t stat,
  output mtpg_pkg::cmd_t       cmd
);
  import mtpg_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.op      = OP_NONE;
    cmd.sel_cnt = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat.mode)
          MODE_ENTER: begin
            cmd.op     = OP_ENTER;
            state_next = ST_IDLE;
          end
          MODE_LEAVE: state_next = ST_LEAVE;
          MODE_TOUCH: begin
            if (!stat.slot_ok) state_next = ST_IDLE;
            else if (stat.is_down) state_next = ST_SCAN;
            else state_next = ST_LIFT;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_last) state_next = ST_REL;
      end
      ST_REL: begin
        if (!stat.hit) begin
          state_next = ST_IDLE;
        end else if (!stat.want_rel) begin
          state_next = ST_PRESS;
        end else if (stat.out_free) begin
          cmd.op     = OP_REL_OLD;
          state_next = ST_PRESS;
        end
      end
      ST_PRESS: begin
        if (!stat.want_press || stat.out_free) begin
          cmd.op     = OP_PRESS;
          state_next = ST_IDLE;
        end
      end
      ST_LEAVE: begin
        cmd.sel_cnt = 1'b1;
        if (!stat.want_leave || stat.out_free) begin
          cmd.op = OP_LEAVE;
          if (stat.slot_last) state_next = ST_IDLE;
        end
      end
      ST_LIFT: begin
        if (!stat.want_lift || stat.out_free) begin
          cmd.op     = OP_LIFT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/pad_tracker_check_pkg.sv =====
// scoreboard class that predicts and checks the pad events of the pad grid tracker
package pad_tracker_check_pkg;
  import mtpg_pkg::*;

  localparam int PAD_COUNT   = GRID_COLS * GRID_ROWS;
  localparam int MAX_EVENTS  = 5;
  localparam int MAX_REPORTS = 60;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] KIND_TRIGGER   = 2'd0;
  localparam logic [1:0] KIND_MOMENTARY = 2'd1;
  localparam logic [1:0] KIND_TOGGLE    = 2'd2;
  localparam logic [1:0] KIND_NONE      = 2'd3;

  typedef struct packed {
    logic       is_press;
    logic [3:0] pad_number;
    logic       pad_level;
    logic       notify;
    logic       last;
  } pad_event_t;

  class pad_event_scoreboard;
    logic [10:0] grid_left;
    logic [10:0] grid_top;
    logic [9:0]  cell_width;
    logic [9:0]  cell_height;
    logic [7:0]  gap_x;
    logic [7:0]  gap_y;
    logic [15:0] assigned_mask;
    logic [31:0] pad_kinds;
    bit          slot_held [TOUCH_SLOTS];
    int          slot_pad  [TOUCH_SLOTS];
    bit          pad_on    [16];
    pad_event_t  expected_pad_events[$];
    pad_event_t  item_events[$];
    int          errors;

    function new();
      grid_left     = 11'd10;
      grid_top      = 11'd40;
      cell_width    = 10'd70;
      cell_height   = 10'd50;
      gap_x         = 8'd5;
      gap_y         = 8'd5;
      assigned_mask = '0;
      pad_kinds     = '0;
      foreach (slot_held[i]) begin
        slot_held[i] = 1'b0;
        slot_pad[i]  = 0;
      end
      foreach (pad_on[i]) pad_on[i] = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_GRID_LEFT:     grid_left     = data[10:0];
        CFG_GRID_TOP:      grid_top      = data[10:0];
        CFG_CELL_WIDTH:    cell_width    = data[9:0];
        CFG_CELL_HEIGHT:   cell_height   = data[9:0];
        CFG_GAP_X:         gap_x         = data[7:0];
        CFG_GAP_Y:         gap_y         = data[7:0];
        CFG_ASSIGNED_MASK: assigned_mask = data[15:0];
        CFG_PAD_KINDS:     pad_kinds     = data;
        default: ;
      endcase
    endfunction

    // first pad in row-major order that contains the point, or -1
    function int find_pad(int x, int y);
      int px;
      int py;
      for (int p = 0; p < PAD_COUNT; p++) begin
        px = int'(grid_left) + (p % GRID_COLS) * (int'(cell_width) + int'(gap_x));
        py = int'(grid_top) + (p / GRID_COLS) * (int'(cell_height) + int'(gap_y));
        if (x >= px && x < px + int'(cell_width) && y >= py && y < py + int'(cell_height))
          return p;
      end
      return -1;
    endfunction

    function void apply_pad_event(int p, bit pressed);
      logic [1:0] kind;
      bit         changed;
      pad_event_t ev;
      if (p >= 16 || !assigned_mask[p]) return;
      kind    = pad_kinds[2*p +: 2];
      changed = 1'b0;
      case (kind)
        KIND_TRIGGER: begin
          pad_on[p] = pressed;
          changed   = pressed;
        end
        KIND_MOMENTARY: begin
          pad_on[p] = pressed;
          changed   = 1'b1;
        end
        KIND_TOGGLE: begin
          if (pressed) begin
            pad_on[p] = ~pad_on[p];
            changed   = 1'b1;
          end
        end
        KIND_NONE: ;
        default: ;
      endcase
      if (item_events.size() >= MAX_EVENTS) return;
      ev.is_press   = pressed;
      ev.pad_number = p[3:0];
      ev.pad_level  = pad_on[p];
      ev.notify     = changed;
      ev.last       = 1'b0;
      item_events.push_back(ev);
    endfunction

    function void note_item(logic [1:0] m, logic [2:0] s, logic [10:0] x, logic [10:0] y,
                            logic down);
      int         hp;
      int         held_pad;
      bit         held_same;
      bit         other;
      bit         still;
      pad_event_t ev;
      item_events.delete();
      case (m)
        MODE_ENTER: begin
          foreach (slot_held[i]) slot_held[i] = 1'b0;
        end
        MODE_LEAVE: begin
          for (int i = 0; i < TOUCH_SLOTS; i++) begin
            if (slot_held[i]) begin
              apply_pad_event(slot_pad[i], 1'b0);
              slot_held[i] = 1'b0;
            end
          end
        end
        MODE_TOUCH: begin
          if (s < TOUCH_SLOTS) begin
            if (down) begin
              hp = find_pad(int'(x), int'(y));
              if (hp >= 0) begin
                held_same = slot_held[s] && slot_pad[s] == hp;
                if (slot_held[s] && slot_pad[s] != hp) apply_pad_event(slot_pad[s], 1'b0);
                other = 1'b0;
                for (int i = 0; i < TOUCH_SLOTS; i++)
                  if (i != s && slot_held[i] && slot_pad[i] == hp) other = 1'b1;
                slot_held[s] = 1'b1;
                slot_pad[s]  = hp;
                if (!other && !held_same) apply_pad_event(hp, 1'b1);
              end
            end else if (slot_held[s]) begin
              held_pad     = slot_pad[s];
              slot_held[s] = 1'b0;
              still        = 1'b0;
              for (int i = 0; i < TOUCH_SLOTS; i++)
                if (slot_held[i] && slot_pad[i] == held_pad) still = 1'b1;
              if (!still) apply_pad_event(held_pad, 1'b0);
            end
          end
        end
        default: ;
      endcase
      if (item_events.size() > 0) begin
        ev      = item_events.pop_back();
        ev.last = 1'b1;
        item_events.push_back(ev);
      end
      foreach (item_events[i]) expected_pad_events.push_back(item_events[i]);
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] got,
                                realtime stamp);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0.1f ns: %s expected %0d, got %0d", stamp, name, want, got);
      end
    endfunction

    function void check_event(logic got_press, logic [3:0] got_pad, logic got_level,
                              logic got_notify, logic got_last, realtime stamp);
      pad_event_t want;
      if (expected_pad_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0.1f ns: no event expected, got press %0b pad %0d level %0b notify %0b last %0b",
                   stamp, got_press, got_pad, got_level, got_notify, got_last);
        return;
      end
      want = expected_pad_events.pop_front();
      compare_field("is_press", 4'(want.is_press), 4'(got_press), stamp);
      compare_field("pad_number", want.pad_number, got_pad, stamp);
      compare_field("pad_level", 4'(want.pad_level), 4'(got_level), stamp);
      compare_field("notify", 4'(want.notify), 4'(got_notify), stamp);
      compare_field("last", 4'(want.last), 4'(got_last), stamp);
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
// testbench for the pad grid tracker: directed and random touch items against a scoreboard
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mtpg_pkg::*;
  import pad_tracker_check_pkg::*;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RANDOM_PHASES  = 11;
  localparam int ITEMS_PER_PHASE = 26;

  localparam int AIM_INSIDE  = 0;
  localparam int AIM_EDGE    = 1;
  localparam int AIM_OUTSIDE = 2;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [31:0] cfg_data   = '0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [1:0]  mode       = '0;
  logic [2:0]  touch_slot = '0;
  logic [10:0] pos_x      = '0;
  logic [10:0] pos_y      = '0;
  logic        is_down    = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        is_press;
  logic [3:0]  pad_number;
  logic        pad_level;
  logic        notify;
  logic        last;

  pad_event_scoreboard board;
  bit          steady      = 1'b0;
  int          ready_hold  = 0;
  int unsigned cycle_count = 0;

  multitouch_pad_grid_tracker_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .touch_slot (touch_slot),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .is_down    (is_down),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_press   (is_press),
    .pad_number (pad_number),
    .pad_level  (pad_level),
    .notify     (notify),
    .last       (last)
  );

  always #5ns clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_event(is_press, pad_number, pad_level, notify, last, $realtime);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] m, input logic [2:0] s, input logic [10:0] x,
                           input logic [10:0] y, input logic d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    touch_slot <= s;
    pos_x      <= x;
    pos_y      <= y;
    is_down    <= d;
    do @(posedge clk); while (!in_ready);
    board.note_item(m, s, x, y, d);
  endtask

  task automatic press(input logic [2:0] s, input logic [10:0] x, input logic [10:0] y);
    send_item(MODE_TOUCH, s, x, y, 1'b1);
  endtask

  task automatic lift(input logic [2:0] s);
    send_item(MODE_TOUCH, s, 11'($urandom), 11'($urandom), 1'b0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  task automatic load_geometry(input int left, input int top, input int w, input int h,
                               input int gx, input int gy, input logic [15:0] mask,
                               input logic [31:0] kinds);
    write_reg(CFG_GRID_LEFT, 32'(left));
    write_reg(CFG_GRID_TOP, 32'(top));
    write_reg(CFG_CELL_WIDTH, 32'(w));
    write_reg(CFG_CELL_HEIGHT, 32'(h));
    write_reg(CFG_GAP_X, 32'(gx));
    write_reg(CFG_GAP_Y, 32'(gy));
    write_reg(CFG_ASSIGNED_MASK, 32'(mask));
    write_reg(CFG_PAD_KINDS, kinds);
    cfg_valid <= 1'b0;
  endtask

  // block idle: all events seen and any silent item finished
  task automatic settle();
    in_valid <= 1'b0;
    while (board.expected_pad_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic aim_at_pad(input int p, input int where, output logic [10:0] x,
                            output logic [10:0] y);
    int w;
    int h;
    int px;
    int py;
    int xv;
    int yv;
    w  = int'(board.cell_width);
    h  = int'(board.cell_height);
    px = int'(board.grid_left) + (p % GRID_COLS) * (w + int'(board.gap_x));
    py = int'(board.grid_top) + (p / GRID_COLS) * (h + int'(board.gap_y));
    case (where)
      AIM_INSIDE: begin
        xv = px + int'($urandom_range(0, w - 1));
        yv = py + int'($urandom_range(0, h - 1));
      end
      AIM_EDGE: begin
        xv = px + ($urandom_range(0, 1) ? w - 1 : 0);
        yv = py + ($urandom_range(0, 1) ? h - 1 : 0);
      end
      default: begin
        xv = $urandom_range(0, 1) ? px + w : px - 1;
        yv = py + int'($urandom_range(0, h - 1));
      end
    endcase
    x = (xv >= 0 && xv <= 2047) ? 11'(xv) : 11'($urandom_range(0, 2047));
    y = (yv >= 0 && yv <= 2047) ? 11'(yv) : 11'($urandom_range(0, 2047));
  endtask

  task automatic send_random_item(output bit counted);
    int          r;
    int          p;
    logic [2:0]  s;
    logic [10:0] x;
    logic [10:0] y;
    r       = $urandom_range(0, 99);
    s       = 3'($urandom_range(0, TOUCH_SLOTS - 1));
    x       = 11'($urandom);
    y       = 11'($urandom);
    p       = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, PAD_COUNT - 1);
    counted = 1'b1;
    if (r < 55) begin
      aim_at_pad(p, ($urandom_range(0, 9) < 7) ? AIM_INSIDE : AIM_EDGE, x, y);
      press(s, x, y);
    end else if (r < 75) begin
      send_item(MODE_TOUCH, s, x, y, 1'b0);
    end else if (r < 80) begin
      press(s, x, y);
    end else if (r < 84) begin
      counted = 1'b0;
      send_item(MODE_TOUCH, 3'($urandom_range(TOUCH_SLOTS, 7)), x, y,
                1'($urandom_range(0, 1)));
    end else if (r < 88) begin
      send_item(MODE_ENTER, s, x, y, 1'($urandom_range(0, 1)));
    end else if (r < 93) begin
      send_item(MODE_LEAVE, s, x, y, 1'($urandom_range(0, 1)));
    end else if (r < 96) begin
      counted = 1'b0;
      send_item(MODE_UNUSED, 3'($urandom), x, y, 1'($urandom_range(0, 1)));
    end else begin
      aim_at_pad(p, AIM_OUTSIDE, x, y);
      press(s, x, y);
    end
  endtask

  task automatic random_config(input int phase);
    logic [15:0] mask;
    mask = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom | $urandom);
    case (phase)
      0: load_geometry(0, 0, 1023, 1023, 255, 255, 16'hFFFF, $urandom);
      1: load_geometry($urandom_range(0, 2044), $urandom_range(0, 2044), 1, 1, 0, 0,
                       mask, $urandom);
      2: load_geometry(2047, 2047, $urandom_range(1, 1023), $urandom_range(1, 1023),
                       $urandom_range(0, 255), $urandom_range(0, 255), 16'hFFFF, $urandom);
      default: load_geometry($urandom_range(0, 400), $urandom_range(0, 400),
                             $urandom_range(20, 400), $urandom_range(20, 400),
                             $urandom_range(0, 40), $urandom_range(0, 40), mask, $urandom);
    endcase
  endtask

  initial begin
    int counted_items;
    bit counted;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset geometry, no pad assigned
    press(3'd0, 11'd45, 11'd65);
    lift(3'd0);
    settle();
    load_geometry(10, 40, 70, 50, 5, 5, 16'hFFFF, 32'hE4E4E4E4);

    // trigger press, move within pad, trigger release
    press(3'd0, 11'd45, 11'd65);
    press(3'd0, 11'd50, 11'd70);
    lift(3'd0);
    // momentary pad shared by two slots, corners inclusive
    press(3'd1, 11'd85, 11'd95);
    press(3'd2, 11'd154, 11'd144);
    lift(3'd1);
    // move onto a toggle pad
    press(3'd2, 11'd160, 11'd40);
    // kind none
    press(3'd3, 11'd235, 11'd40);
    // right edge exclusive lands in the gap
    press(3'd4, 11'd155, 11'd95);
    press(3'd4, 11'd304, 11'd89);
    // ignored items
    press(3'd5, 11'd45, 11'd65);
    press(3'd7, 11'd45, 11'd65);
    send_item(MODE_UNUSED, 3'd6, 11'd2047, 11'd2047, 1'b1);
    // release per holder
    send_item(MODE_LEAVE, 3'd0, 11'd0, 11'd0, 1'b0);
    press(3'd0, 11'd160, 11'd40);
    send_item(MODE_ENTER, 3'd0, 11'd0, 11'd0, 1'b1);
    lift(3'd0);
    press(3'd0, 11'd2047, 11'd2047);
    press(3'd1, 11'd0, 11'd0);
    // old pad released even while another slot holds it
    press(3'd0, 11'd45, 11'd65);
    press(3'd1, 11'd45, 11'd65);
    press(3'd0, 11'd100, 11'd50);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      steady = (phase % 4 == 3);
      random_config(phase);
      counted_items = 0;
      while (counted_items < ITEMS_PER_PHASE) begin
        send_random_item(counted);
        counted_items += counted;
      end
    end

    settle();
    if (board.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mtpg_pkg.sv
sv/mtpg_datapath.sv
sv/mtpg_ctrl.sv
sv/multitouch_pad_grid_tracker_unit.sv
tb/pad_tracker_check_pkg.sv
tb/testbench.sv
